### rtl/assert_macros.svh
// Assertion macros used by the checker file iaef_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, ignored while reset is asserted.
`define IAEF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds through reset.
`define IAEF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/iaef_pkg.sv
`default_nettype none
package iaef_pkg;

  localparam int unsigned XLEN      = 64;
  localparam int unsigned HALF      = XLEN / 2;
  localparam int unsigned REG_COUNT = 32;
  localparam int unsigned IDX_W     = $clog2(REG_COUNT);
  localparam int unsigned IMM_W     = 12;
  localparam int unsigned IMM_SHIFT = 12;
  localparam int unsigned SIGN_BIT  = 63;

  localparam logic [IDX_W-1:0] ZERO_REG = IDX_W'(31);
  localparam logic [XLEN-1:0]  PC_STEP  = XLEN'(4);

  typedef enum logic [3:0] {
    KIND_ADDS_REG = 4'd0,
    KIND_ADDS_IMM = 4'd1,
    KIND_SUBS_REG = 4'd2,
    KIND_SUBS_IMM = 4'd3,
    KIND_ANDS     = 4'd4,
    KIND_EOR      = 4'd5,
    KIND_ORR      = 4'd6,
    KIND_SUB_IMM  = 4'd7,
    KIND_SUB_REG  = 4'd8,
    KIND_ADD_IMM  = 4'd9,
    KIND_ADD_REG  = 4'd10,
    KIND_MUL      = 4'd11
  } kind_t;

  typedef struct packed {
    logic [XLEN-1:0] alu;
    logic [XLEN-1:0] p_ll;
    logic [HALF-1:0] p_lh;
    logic [HALF-1:0] p_hl;
  } alu_res_t;

  function automatic logic kind_valid(input kind_t k);
    return k inside {[KIND_ADDS_REG:KIND_MUL]};
  endfunction

  function automatic logic sets_flags(input kind_t k);
    return k inside {KIND_ADDS_REG, KIND_ADDS_IMM, KIND_SUBS_REG, KIND_SUBS_IMM, KIND_ANDS};
  endfunction

  function automatic logic uses_imm(input kind_t k);
    return k inside {KIND_ADDS_IMM, KIND_SUBS_IMM, KIND_SUB_IMM, KIND_ADD_IMM};
  endfunction

  function automatic logic is_sub(input kind_t k);
    return k inside {KIND_SUBS_REG, KIND_SUBS_IMM, KIND_SUB_IMM, KIND_SUB_REG};
  endfunction

endpackage
`default_nettype wire

### rtl/iaef_regfile.sv
`default_nettype none
module iaef_regfile (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [iaef_pkg::IDX_W-1:0] rd_addr_a,
  input  wire logic [iaef_pkg::IDX_W-1:0] rd_addr_b,
  input  wire logic                       wr_en,
  input  wire logic [iaef_pkg::IDX_W-1:0] wr_addr,
  input  wire logic [iaef_pkg::XLEN-1:0]  wr_data,
  output logic      [iaef_pkg::XLEN-1:0]  rd_data_a,
  output logic      [iaef_pkg::XLEN-1:0]  rd_data_b
);
  import iaef_pkg::*;

  logic [XLEN-1:0]      mem [REG_COUNT];
  logic [REG_COUNT-1:0] vld_r;
  logic [XLEN-1:0]      data_a_r;
  logic [XLEN-1:0]      data_b_r;
  logic                 vld_a_r;
  logic                 vld_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    data_a_r <= mem[rd_addr_a];
    data_b_r <= mem[rd_addr_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      vld_a_r <= vld_r[rd_addr_a];
      vld_b_r <= vld_r[rd_addr_b];
    end
  end

  // unwritten entries, register 31 included, read zero
  assign rd_data_a = vld_a_r ? data_a_r : '0;
  assign rd_data_b = vld_b_r ? data_b_r : '0;

endmodule
`default_nettype wire

### rtl/iaef_alu.sv
`default_nettype none
module iaef_alu (
  input  wire iaef_pkg::kind_t            kind,
  input  wire logic [iaef_pkg::XLEN-1:0]  opa,
  input  wire logic [iaef_pkg::XLEN-1:0]  opb,
  input  wire logic [iaef_pkg::IMM_W-1:0] imm_value,
  input  wire logic                       imm_shift,
  output iaef_pkg::alu_res_t              res
);
  import iaef_pkg::*;

  logic [XLEN-1:0] imm_ext;
  logic [XLEN-1:0] opnd;
  logic [XLEN-1:0] sum;

  always_comb begin
    imm_ext = imm_shift ? (XLEN'(imm_value) << IMM_SHIFT) : XLEN'(imm_value);
    opnd    = uses_imm(kind) ? imm_ext : opb;
    sum     = is_sub(kind) ? (opa - opnd) : (opa + opnd);

    case (kind)
      KIND_ADDS_REG, KIND_ADDS_IMM, KIND_SUBS_REG, KIND_SUBS_IMM,
      KIND_SUB_IMM, KIND_SUB_REG, KIND_ADD_IMM, KIND_ADD_REG: begin
        res.alu = sum;
      end
      KIND_ANDS: begin
        res.alu = opa & opb;
      end
      KIND_EOR: begin
        res.alu = opa ^ opb;
      end
      KIND_ORR: begin
        res.alu = opa | opb;
      end
      default: begin
        res.alu = '0;
      end
    endcase

    // low half of the product as three partial products, summed next stage
    res.p_ll = XLEN'(opa[HALF-1:0]) * XLEN'(opb[HALF-1:0]);
    res.p_lh = opa[HALF-1:0] * opb[XLEN-1:HALF];
    res.p_hl = opa[XLEN-1:HALF] * opb[HALF-1:0];
  end

endmodule
`default_nettype wire

### rtl/integer_alu_execute_with_flags.sv
// Pipeline: input word -> first stage -> second stage -> result register. Throughput:
// one word per cycle while the output is not stalled; a bubble when a word reads the
// destination of a multiply in the second stage, where its product sum is formed.
// Reset: synchronous, active low; empties the pipeline, clears PC and N/Z flags,
// and clears the register-file valid bits so every register reads zero at once.
`default_nettype none
module integer_alu_execute_with_flags (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  in_kind,
  input  wire logic [4:0]  in_dest_index,
  input  wire logic [4:0]  in_first_source_index,
  input  wire logic [4:0]  in_second_source_index,
  input  wire logic [11:0] in_imm_value,
  input  wire logic        in_imm_shift,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [63:0] out_result_value,
  output logic             out_wrote_register,
  output logic             out_negative_flag,
  output logic             out_zero_flag,
  output logic [63:0]      out_next_pc
);
  import iaef_pkg::*;

  logic             s1_v_r;
  kind_t            s1_kind_r;
  logic [IDX_W-1:0] s1_rd_r;
  logic [IDX_W-1:0] s1_rn_r;
  logic [IDX_W-1:0] s1_rm_r;
  logic [IMM_W-1:0] s1_imm_r;
  logic             s1_sh_r;

  logic             s2_v_r;
  kind_t            s2_kind_r;
  logic [IDX_W-1:0] s2_rd_r;
  logic             s2_wr_r;
  alu_res_t         s2_res_r;

  logic             wb_v_r;
  logic [IDX_W-1:0] wb_idx_r;
  logic [XLEN-1:0]  wb_data_r;

  logic             out_v_r;
  logic [XLEN-1:0]  out_res_r;
  logic             out_wr_r;
  logic             n_r;
  logic             z_r;
  logic [XLEN-1:0]  pc_r;

  logic             out_ready;
  logic             s2_move;
  logic             s2_free;
  logic             s1_move;
  logic             s1_load;
  logic             hazard;
  logic [IDX_W-1:0] rd_addr_a;
  logic [IDX_W-1:0] rd_addr_b;
  logic [XLEN-1:0]  rf_a;
  logic [XLEN-1:0]  rf_b;
  logic [XLEN-1:0]  opa;
  logic [XLEN-1:0]  opb;
  alu_res_t         alu_res;
  logic [XLEN-1:0]  res2;
  logic             n_nxt;
  logic             z_nxt;
  logic [XLEN-1:0]  pc_nxt;
  logic             s2_fwd_ok;

  always_comb begin
    out_ready = !out_v_r || !out_stall;
    s2_move   = s2_v_r && out_ready;
    s2_free   = !s2_v_r || out_ready;
    s2_fwd_ok = s2_v_r && s2_wr_r;
    hazard    = s2_fwd_ok && (s2_kind_r == KIND_MUL) &&
                ((s2_rd_r == s1_rn_r) || (s2_rd_r == s1_rm_r));
    s1_move   = s1_v_r && s2_free && !hazard;
    in_stall  = s1_v_r && !s1_move;
    s1_load   = in_valid && !in_stall;
    rd_addr_a = s1_load ? in_first_source_index  : s1_rn_r;
    rd_addr_b = s1_load ? in_second_source_index : s1_rm_r;
  end

  iaef_regfile u_rf (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .wr_en     (s2_move && s2_wr_r),
    .wr_addr   (s2_rd_r),
    .wr_data   (res2),
    .rd_data_a (rf_a),
    .rd_data_b (rf_b)
  );

  // forward: second stage first, then the write of the last edge, then the array
  always_comb begin
    if (s2_fwd_ok && s2_rd_r == s1_rn_r) begin
      opa = s2_res_r.alu;
    end else if (wb_v_r && wb_idx_r == s1_rn_r) begin
      opa = wb_data_r;
    end else begin
      opa = rf_a;
    end
    if (s2_fwd_ok && s2_rd_r == s1_rm_r) begin
      opb = s2_res_r.alu;
    end else if (wb_v_r && wb_idx_r == s1_rm_r) begin
      opb = wb_data_r;
    end else begin
      opb = rf_b;
    end
  end

  iaef_alu u_alu (
    .kind      (s1_kind_r),
    .opa       (opa),
    .opb       (opb),
    .imm_value (s1_imm_r),
    .imm_shift (s1_sh_r),
    .res       (alu_res)
  );

  always_comb begin
    if (s2_kind_r == KIND_MUL) begin
      res2 = s2_res_r.p_ll + {s2_res_r.p_lh + s2_res_r.p_hl, HALF'(0)};
    end else begin
      res2 = s2_res_r.alu;
    end
    if (sets_flags(s2_kind_r)) begin
      n_nxt = s2_res_r.alu[SIGN_BIT];
      z_nxt = (s2_res_r.alu == '0);
    end else begin
      n_nxt = n_r;
      z_nxt = z_r;
    end
    pc_nxt = pc_r + PC_STEP;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      wb_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      n_r     <= 1'b0;
      z_r     <= 1'b0;
      pc_r    <= '0;
    end else begin
      if (s1_load) begin
        s1_v_r <= 1'b1;
      end else if (s1_move) begin
        s1_v_r <= 1'b0;
      end
      if (s1_move) begin
        s2_v_r <= 1'b1;
      end else if (s2_move) begin
        s2_v_r <= 1'b0;
      end
      wb_v_r <= s2_move && s2_wr_r;
      if (s2_move) begin
        out_v_r <= 1'b1;
        n_r     <= n_nxt;
        z_r     <= z_nxt;
        pc_r    <= pc_nxt;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_kind_r <= kind_t'(in_kind);
      s1_rd_r   <= in_dest_index;
      s1_rn_r   <= in_first_source_index;
      s1_rm_r   <= in_second_source_index;
      s1_imm_r  <= in_imm_value;
      s1_sh_r   <= in_imm_shift;
    end
    if (s1_move) begin
      s2_kind_r <= s1_kind_r;
      s2_rd_r   <= s1_rd_r;
      s2_wr_r   <= kind_valid(s1_kind_r) && (s1_rd_r != ZERO_REG);
      s2_res_r  <= alu_res;
    end
    if (s2_move) begin
      wb_idx_r    <= s2_rd_r;
      wb_data_r   <= res2;
      out_res_r   <= res2;
      out_wr_r    <= s2_wr_r;
    end
  end

  assign out_valid          = out_v_r;
  assign out_result_value   = out_res_r;
  assign out_wrote_register = out_wr_r;
  assign out_negative_flag  = n_r;
  assign out_zero_flag      = z_r;
  assign out_next_pc        = pc_r;

endmodule
`default_nettype wire

### rtl/iaef_checker.sv
`default_nettype none
`include "assert_macros.svh"
module iaef_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [63:0] out_result_value,
  input wire logic [63:0] out_next_pc
);

  `IAEF_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "output valid after reset")
  `IAEF_ASSERT_ALWAYS(a_reset_ready, !rst_n |=> !in_stall, "input stalled after reset")
  `IAEF_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_result_value) && $stable(out_next_pc), "stalled output word changed")
  `IAEF_ASSERT(a_pc_step, (out_valid && !out_stall) ##1 out_valid |-> out_next_pc == $past(out_next_pc) + 64'd4, "next_pc did not advance by four")
  `IAEF_ASSERT(a_pc_align, out_valid |-> out_next_pc[1:0] == 2'b00, "next_pc misaligned")

endmodule

bind integer_alu_execute_with_flags iaef_checker u_iaef_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_result_value (out_result_value),
  .out_next_pc      (out_next_pc)
);
`default_nettype wire
